/* rtl/polyline_point_interpolator_core_macros.svh */
// Assertion macros for the polyline point interpolator.
// Used by the top level; no other dependencies.
`ifndef POLYLINE_POINT_INTERPOLATOR_CORE_MACROS_SVH
`define POLYLINE_POINT_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define PPI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ppi_pkg.sv */
// Shared types and constants for the polyline point interpolator.
// No dependencies.
package ppi_pkg;

	localparam int CRD_W            = 16;
	localparam int DVS_W            = 8;
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam logic [DVS_W-1:0] SPACING_RESET = 8'd8;

	typedef struct packed {
		logic signed [CRD_W-1:0] vertex_x;
		logic signed [CRD_W-1:0] vertex_y;
		logic                    path_start;
	} ppi_in_t;

	typedef struct packed {
		logic signed [CRD_W-1:0] point_x;
		logic signed [CRD_W-1:0] point_y;
		logic                    is_vertex;
		logic                    last_of_run;
	} ppi_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DELTA,
		ST_SCALE,
		ST_STEPS,
		ST_LDX,
		ST_WDX,
		ST_LDY,
		ST_WDY,
		ST_PUT,
		ST_VTX
	} ppi_state_t;

endpackage

/* rtl/polyline_point_interpolator_core.sv */
// Polyline resampler: each request carries one vertex. A vertex that opens a path, or the first
// vertex after reset, leaves as one point. Any other vertex first has its step count worked out
// with NUM_W = 16 + log2(MAX_SEGMENTS), then each interpolated point is made, both of its
// coordinates going through the one shared bit-serial divider; the vertex itself follows.
// A busy output stalls it.
// Depends on ppi_pkg, ppi_div and polyline_point_interpolator_core_macros.svh.
`include "polyline_point_interpolator_core_macros.svh"

module polyline_point_interpolator_core import ppi_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vertex_valid,
	output logic             vertex_ready,
	input  ppi_in_t          vertex,
	output logic             point_valid,
	input  logic             point_ready,
	output ppi_out_t         point,
	input  logic             spacing_we,
	input  logic [DVS_W-1:0] spacing_wdata
);

	localparam int STEP_W = $clog2(MAX_SEGMENTS + 1);
	localparam int NUM_W  = CRD_W + $clog2(MAX_SEGMENTS);
	localparam int ACC_W  = NUM_W + 1;

	ppi_state_t state_q, state_d;

	logic [DVS_W-1:0]        spacing_q;
	logic                    have_prev_q;
	logic signed [CRD_W-1:0] prev_x_q, prev_y_q;
	logic signed [CRD_W-1:0] vx_q, vy_q;
	logic signed [CRD_W:0]   dx_q, dy_q;
	logic [STEP_W-1:0]       steps_q, j_q;
	logic signed [ACC_W-1:0] acc_x_q, acc_y_q;
	logic [CRD_W-1:0]        px_q, py_q;
	logic                    out_valid_q;
	ppi_out_t                out_q;

	logic                    div_start, div_done;
	logic [NUM_W-1:0]        div_num, div_q;
	logic [DVS_W-1:0]        div_dvs;

	logic                    accept, slot_free;
	logic                    ld_delta, ld_steps, ld_px, ld_py, put_pt, put_vtx;

	logic [DVS_W-1:0]        sp_eff;
	logic [CRD_W:0]          abs_dx, abs_dy;
	logic [CRD_W-1:0]        mag;
	logic [STEP_W-1:0]       steps_sat;
	logic [ACC_W-1:0]        abs_ax, abs_ay;
	logic signed [ACC_W-1:0] dx_ext, dy_ext;
	logic [CRD_W-1:0]        qs, off;
	logic                    q_neg;

	assign accept    = vertex_valid && vertex_ready;
	assign slot_free = !out_valid_q || point_ready;

	assign sp_eff = (spacing_q == '0) ? DVS_W'(1) : spacing_q;
	assign abs_dx = dx_q[CRD_W] ? -dx_q : dx_q;
	assign abs_dy = dy_q[CRD_W] ? -dy_q : dy_q;
	assign mag    = (abs_dx > abs_dy) ? abs_dx[CRD_W-1:0] : abs_dy[CRD_W-1:0];

	assign steps_sat = (div_q > NUM_W'(MAX_SEGMENTS)) ? STEP_W'(MAX_SEGMENTS)
		: div_q[STEP_W-1:0];

	assign dx_ext = ACC_W'(dx_q);
	assign dy_ext = ACC_W'(dy_q);
	assign abs_ax = acc_x_q[ACC_W-1] ? ACC_W'(-acc_x_q) : ACC_W'(acc_x_q);
	assign abs_ay = acc_y_q[ACC_W-1] ? ACC_W'(-acc_y_q) : ACC_W'(acc_y_q);

	// quotient magnitude back to a signed offset, mod 2^16
	assign qs    = div_q[CRD_W-1:0];
	assign q_neg = (state_q == ST_WDX) ? acc_x_q[ACC_W-1] : acc_y_q[ACC_W-1];
	assign off   = q_neg ? (~qs + CRD_W'(1)) : qs;

	always_comb begin
		div_num = abs_ay[NUM_W-1:0];
		div_dvs = DVS_W'(steps_q);
		case (state_q)
			ST_SCALE: begin
				div_num = NUM_W'(mag) + NUM_W'(sp_eff >> 1);
				div_dvs = sp_eff;
			end
			ST_LDX:   div_num = abs_ax[NUM_W-1:0];
			default:  div_num = abs_ay[NUM_W-1:0];
		endcase
	end

	ppi_div #(
		.NUM_W(NUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_dvs),
		.done    (div_done),
		.quotient(div_q)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (vertex_valid) begin
					state_d = (vertex.path_start || !have_prev_q) ? ST_VTX : ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_STEPS;
			ST_STEPS: begin
				if (div_done) begin
					state_d = (steps_sat <= STEP_W'(1)) ? ST_VTX : ST_LDX;
				end
			end
			ST_LDX: state_d = ST_WDX;
			ST_WDX: begin
				if (div_done) begin
					state_d = ST_LDY;
				end
			end
			ST_LDY: state_d = ST_WDY;
			ST_WDY: begin
				if (div_done) begin
					state_d = ST_PUT;
				end
			end
			ST_PUT: begin
				if (slot_free) begin
					state_d = ((j_q + STEP_W'(1)) == steps_q) ? ST_VTX : ST_LDX;
				end
			end
			ST_VTX: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		vertex_ready = 1'b0;
		div_start    = 1'b0;
		ld_delta     = 1'b0;
		ld_steps     = 1'b0;
		ld_px        = 1'b0;
		ld_py        = 1'b0;
		put_pt       = 1'b0;
		put_vtx      = 1'b0;
		case (state_q)
			ST_IDLE:  vertex_ready = 1'b1;
			ST_DELTA: ld_delta     = 1'b1;
			ST_SCALE: div_start    = 1'b1;
			ST_STEPS: ld_steps     = div_done;
			ST_LDX:   div_start    = 1'b1;
			ST_WDX:   ld_px        = div_done;
			ST_LDY:   div_start    = 1'b1;
			ST_WDY:   ld_py        = div_done;
			ST_PUT:   put_pt       = slot_free;
			ST_VTX:   put_vtx      = slot_free;
			default:  vertex_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			spacing_q   <= SPACING_RESET;
			have_prev_q <= 1'b0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (spacing_we) begin
				spacing_q <= spacing_wdata;
			end
			if (put_vtx) begin
				have_prev_q <= 1'b1;
				prev_x_q    <= vx_q;
				prev_y_q    <= vy_q;
			end
			if (put_pt || put_vtx) begin
				out_valid_q <= 1'b1;
			end else if (point_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vx_q <= vertex.vertex_x;
			vy_q <= vertex.vertex_y;
		end
		if (ld_delta) begin
			dx_q <= (CRD_W+1)'(vx_q) - (CRD_W+1)'(prev_x_q);
			dy_q <= (CRD_W+1)'(vy_q) - (CRD_W+1)'(prev_y_q);
		end
		if (ld_steps) begin
			steps_q <= steps_sat;
			j_q     <= STEP_W'(1);
			acc_x_q <= dx_ext;
			acc_y_q <= dy_ext;
		end
		if (ld_px) begin
			px_q <= prev_x_q + off;
		end
		if (ld_py) begin
			py_q <= prev_y_q + off;
		end
		if (put_pt) begin
			j_q     <= j_q + STEP_W'(1);
			acc_x_q <= acc_x_q + dx_ext;
			acc_y_q <= acc_y_q + dy_ext;
			out_q   <= '{point_x: px_q, point_y: py_q, is_vertex: 1'b0, last_of_run: 1'b0};
		end
		if (put_vtx) begin
			out_q <= '{point_x: vx_q, point_y: vy_q, is_vertex: 1'b1, last_of_run: 1'b1};
		end
	end

	assign point_valid = out_valid_q;
	assign point       = out_q;

	`PPI_ASSERT_NOW(a_last_is_vertex, clk, arst_n, point_valid && point.last_of_run, point.is_vertex, "last point of a run is not the vertex")
	`PPI_ASSERT_NOW(a_div_done_waited, clk, arst_n, div_done, (state_q == ST_STEPS) || (state_q == ST_WDX) || (state_q == ST_WDY), "divider finished outside a wait state")
	`PPI_ASSERT_NOW(a_step_index, clk, arst_n, state_q == ST_PUT, (j_q < steps_q) && (steps_q >= STEP_W'(2)), "interpolation index out of range")
	`PPI_ASSERT_NEXT(a_start_direct, clk, arst_n, accept && vertex.path_start, state_q == ST_VTX, "path start did not go straight to the vertex")

endmodule

/* rtl/ppi_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on ppi_pkg.
module ppi_div import ppi_pkg::*; #(
	parameter int NUM_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* test/ppi_checker.sv */
// Point checker for the polyline point interpolator: watches the vertex and point channels and the
// spacing register port, predicts the points of every vertex and compares them in order.
// Depends on ppi_pkg.
module ppi_checker import ppi_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vertex_valid,
	input  logic             vertex_ready,
	input  ppi_in_t          vertex,
	input  logic             point_valid,
	input  logic             point_ready,
	input  ppi_out_t         point,
	input  logic             spacing_we,
	input  logic [DVS_W-1:0] spacing_wdata,
	output int               pending,
	output int               fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	ppi_out_t         expected_points[$];
	ppi_out_t         want;
	int               last_x = 0;
	int               last_y = 0;
	bit               have_last = 1'b0;
	logic [DVS_W-1:0] cur_spacing = SPACING_RESET;
	int               fails = 0;

	task automatic predict_points(input ppi_in_t v);
		int vx, vy, dx, dy, ax, ay, span, div, steps;
		ppi_out_t p;
		vx = int'($signed(v.vertex_x));
		vy = int'($signed(v.vertex_y));
		if (!v.path_start && have_last) begin
			dx = vx - last_x;
			dy = vy - last_y;
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			span = (ax > ay) ? ax : ay;
			div = (cur_spacing == '0) ? 1 : int'(cur_spacing);
			steps = (span + div / 2) / div;
			if (steps > MAX_SEGMENTS)
				steps = MAX_SEGMENTS;
			// interior points, divisions truncate toward zero
			for (int j = 1; j < steps; j++) begin
				p.point_x = CRD_W'(last_x + (j * dx) / steps);
				p.point_y = CRD_W'(last_y + (j * dy) / steps);
				p.is_vertex = 1'b0;
				p.last_of_run = 1'b0;
				expected_points.push_back(p);
			end
		end
		p.point_x = v.vertex_x;
		p.point_y = v.vertex_y;
		p.is_vertex = 1'b1;
		p.last_of_run = 1'b1;
		expected_points.push_back(p);
		last_x = vx;
		last_y = vy;
		have_last = 1'b1;
	endtask

	function automatic void check_field(string name, int exp_val, int got_val);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_points.delete();
			last_x = 0;
			last_y = 0;
			have_last = 1'b0;
			cur_spacing = SPACING_RESET;
			pending <= 0;
		end else begin
			if (point_valid && point_ready) begin
				if (expected_points.size() == 0) begin
					$error("unexpected point x=%0d y=%0d", $signed(point.point_x),
						$signed(point.point_y));
					fails++;
				end else begin
					want = expected_points.pop_front();
					check_field("point_x", int'($signed(want.point_x)),
						int'($signed(point.point_x)));
					check_field("point_y", int'($signed(want.point_y)),
						int'($signed(point.point_y)));
					check_field("is_vertex", int'(want.is_vertex), int'(point.is_vertex));
					check_field("last_of_run", int'(want.last_of_run), int'(point.last_of_run));
				end
			end
			if (spacing_we)
				cur_spacing = spacing_wdata;
			if (vertex_valid && vertex_ready)
				predict_points(vertex);
			pending <= expected_points.size();
		end
		fail_count <= fails;
	end

endmodule

/* test/tb_top.sv */
// Testbench top for the polyline point interpolator: drives vertex requests and the spacing
// register, throttles the point channel and gives the verdict.
// Depends on ppi_pkg, polyline_point_interpolator_core and ppi_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ppi_pkg::*;

	localparam int HOLD_CYCLES   = 1500;
	localparam int IDLE_LIMIT    = 20000;
	localparam int TAIL_CYCLES   = 300;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 33;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             vertex_valid = 1'b0;
	logic             vertex_ready;
	ppi_in_t          vertex = '0;
	logic             point_valid;
	logic             point_ready = 1'b0;
	ppi_out_t         point;
	logic             spacing_we = 1'b0;
	logic [DVS_W-1:0] spacing_wdata = '0;

	int                      pending;
	int                      fail_count;
	int                      idle_cycles = 0;
	int                      spacing_now = int'(SPACING_RESET);
	bit                      hold_req = 1'b0;
	bit                      burst_mode = 1'b0;
	logic signed [CRD_W-1:0] sent_x = '0;
	logic signed [CRD_W-1:0] sent_y = '0;

	polyline_point_interpolator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.spacing_we   (spacing_we),
		.spacing_wdata(spacing_wdata)
	);

	ppi_checker point_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_valid (vertex_valid),
		.vertex_ready (vertex_ready),
		.vertex       (vertex),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.spacing_we   (spacing_we),
		.spacing_wdata(spacing_wdata),
		.pending      (pending),
		.fail_count   (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 15);
		else
			return $urandom_range(30, 90);
	endfunction

	task automatic send_vertex(input int x, input int y, input logic start);
		ppi_in_t v;
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			vertex_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		v.vertex_x = CRD_W'(x);
		v.vertex_y = CRD_W'(y);
		v.path_start = start;
		vertex <= v;
		vertex_valid <= 1'b1;
		@(posedge clk);
		while (!vertex_ready)
			@(posedge clk);
		sent_x = CRD_W'(x);
		sent_y = CRD_W'(y);
	endtask

	task automatic send_random_vertex();
		int r, reach, dx, dy;
		r = $urandom_range(0, 15);
		if (r < 3) begin
			send_vertex(int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
				r < 2);
		end else begin
			// short hop from the last vertex, a few spacings long
			reach = ((spacing_now == 0) ? 1 : spacing_now) * $urandom_range(0, 12)
				+ $urandom_range(0, spacing_now);
			dx = $urandom_range(0, reach);
			dy = $urandom_range(0, reach);
			if ($urandom_range(0, 1))
				dx = -dx;
			if ($urandom_range(0, 1))
				dy = -dy;
			send_vertex(int'(sent_x) + dx, int'(sent_y) + dy, 1'b0);
		end
	endtask

	task automatic wait_all_points();
		vertex_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic write_spacing(input int value);
		spacing_wdata <= DVS_W'(value);
		spacing_we <= 1'b1;
		@(posedge clk);
		spacing_we <= 1'b0;
		spacing_now = value;
	endtask

	// point receiver: random ready bursts and gaps, one long hold on request
	initial begin
		int rdy_left;
		bit rdy_on;
		bit held;
		rdy_left = 0;
		rdy_on = 1'b0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				point_ready <= 1'b0;
				rdy_on = 1'b0;
				held = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rdy_left = 0;
			end else if (rdy_left == 0) begin
				rdy_on = !rdy_on;
				if (rdy_on)
					rdy_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 20);
				else
					rdy_left = pick_gap() + 1;
				point_ready <= rdy_on;
			end else begin
				rdy_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (vertex_valid && vertex_ready) || (point_valid && point_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset spacing: first vertex without path start, zero steps, rounding
		send_vertex(100, -50, 1'b0);
		send_vertex(100, -50, 1'b0);
		send_vertex(103, -50, 1'b0);
		send_vertex(104, -50, 1'b0);
		send_vertex(116, -50, 1'b0);
		send_vertex(156, -80, 1'b0);
		send_vertex(-32768, -32768, 1'b1);
		send_vertex(32767, 32767, 1'b0);
		send_vertex(-32768, 32767, 1'b0);
		send_vertex(0, 0, 1'b1);
		send_vertex(-23, 37, 1'b0);
		send_vertex(-23, 37, 1'b1);
		send_vertex(32767, -32768, 1'b0);
		wait_all_points();

		// spacing zero acts as one
		write_spacing(0);
		send_vertex(5, 5, 1'b1);
		send_vertex(5, -3, 1'b0);
		send_vertex(70, -3, 1'b0);
		send_vertex(69, -3, 1'b0);
		wait_all_points();

		write_spacing(255);
		send_vertex(0, 0, 1'b1);
		send_vertex(127, 0, 1'b0);
		send_vertex(255, 0, 1'b0);
		send_vertex(-32768, 32767, 1'b0);
		wait_all_points();

		write_spacing(1);
		send_vertex(0, 0, 1'b1);
		send_vertex(3, -2, 1'b0);
		wait_all_points();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				1: write_spacing(255);
				2: write_spacing(1);
				3: write_spacing(0);
				5: write_spacing(int'(SPACING_RESET));
				default: write_spacing($urandom_range(2, 254));
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 1 && i == 0)
					hold_req = 1'b1;
				burst_mode = (ph == 2) || (ph == 1 && i < 8);
				send_random_vertex();
			end
			burst_mode = 1'b0;
			wait_all_points();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/ppi_pkg.sv
rtl/ppi_div.sv
rtl/polyline_point_interpolator_core.sv
test/ppi_checker.sv
test/tb_top.sv
